>>> sv/ffpa_pkg.sv
// shared types and constants of the first-fit pool allocator
// no dependencies; imported by every module of the block
package ffpa_pkg;

  localparam int OFF_W = 21;
  localparam int SZ_W  = 21;
  localparam int REQ_W = 21;
  localparam int REL_W = 20;
  localparam int GR_W  = 20;
  localparam int ST_W  = 2;
  localparam int OP_W  = 3;

  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPACT = 3'd3;
  localparam logic [OP_W-1:0] OP_ANALYZE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOPOOL  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

  localparam logic [2:0] REG_POOL_BYTES = 3'd0;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [SZ_W-1:0]  size;
    logic             free;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_READ, S_PROC, S_SPLIT, S_FLUSH, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic create;
    logic rd;
    logic proc;
    logic split;
    logic flush;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_create;
    logic walk;
    logic split_req;
    logic walk_end;
  } sts_t;

endpackage

>>> sv/first_fit_pool_allocator.sv
// First-fit pool allocator. The block table sits in a single-port-read memory
// holding two copies; every alloc, free, compact or analyze item on a created
// pool streams the live copy into the other one entry at a time, splitting or
// merging on the way, then swaps. Each table entry is read and then processed,
// with an extra split step where a block is split; create, no-pool and unused
// opcodes skip the walk and go straight to the result.
// A new item is taken while a result still waits in the output register.
module first_fit_pool_allocator
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS     = 64,
  parameter int HEADER_BYTES   = 32,
  parameter int POOL_ADDR_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[2:0], request_bytes[23:3], release_offset[43:24], zero fill
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], granted_offset[21:2], used_bytes[42:22],
  // free_block_count[49:43], total_free_bytes[70:50],
  // largest_free_bytes[91:71], merged_count[97:92], zero fill
  output logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cmd_t            cmd;
  sts_t            sts;
  logic [SZ_W-1:0] pool_bytes_r;
  logic [ST_W-1:0] o_status;
  logic [GR_W-1:0] o_granted;
  logic [SZ_W-1:0] o_used, o_tfree, o_lfree;
  logic [6:0]      o_nfree;
  logic [5:0]      o_merged;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_POOL_BYTES) ? {11'd0, pool_bytes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_bytes_r <= SZ_W'(1048576);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_POOL_BYTES) begin
      pool_bytes_r <= cfg_pwdata[SZ_W-1:0];
    end
  end

  ffpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ffpa_dp #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .HEADER_BYTES   (HEADER_BYTES),
    .POOL_ADDR_BITS (POOL_ADDR_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_tdata[2:0]),
    .in_request_bytes     (in_tdata[23:3]),
    .in_release_offset    (in_tdata[43:24]),
    .pool_bytes           (pool_bytes_r),
    .o_status             (o_status),
    .o_granted_offset     (o_granted),
    .o_used_bytes         (o_used),
    .o_free_block_count   (o_nfree),
    .o_total_free_bytes   (o_tfree),
    .o_largest_free_bytes (o_lfree),
    .o_merged_count       (o_merged)
  );

  assign out_tdata = {6'd0, o_merged, o_lfree, o_tfree, o_nfree, o_used, o_granted, o_status};

endmodule

>>> sv/ffpa_ctrl.sv
// sequencer of the allocator: walks the block table one entry at a time
// depends on ffpa_pkg
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_create) begin
          cmd.create = 1'b1;
          state_nxt  = S_DONE;
        end else if (sts.walk) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PROC;
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (sts.split_req) state_nxt = S_SPLIT;
        else if (sts.walk_end) state_nxt = S_FLUSH;
        else state_nxt = S_READ;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = sts.walk_end ? S_FLUSH : S_READ;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> sv/ffpa_dp.sv
// datapath of the allocator: ping-pong block table memory, held entry,
// merge/split logic, counters and the result register; depends on ffpa_pkg
module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS     = 64,
  parameter int HEADER_BYTES   = 32,
  parameter int POOL_ADDR_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [REL_W-1:0] in_release_offset,
  input  logic [SZ_W-1:0]  pool_bytes,
  output logic [ST_W-1:0]  o_status,
  output logic [GR_W-1:0]  o_granted_offset,
  output logic [SZ_W-1:0]  o_used_bytes,
  output logic [6:0]       o_free_block_count,
  output logic [SZ_W-1:0]  o_total_free_bytes,
  output logic [SZ_W-1:0]  o_largest_free_bytes,
  output logic [5:0]       o_merged_count
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam logic [32:0] POOL_LIMIT = 33'd1 << POOL_ADDR_BITS;

  ent_t mem [0:MEM_DEPTH-1];
  ent_t rd_q_r;

  logic             bank_r, bank_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             present_r, present_nxt;
  logic [SZ_W-1:0]  used_r, used_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [REL_W-1:0] rel_r, rel_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] wr_idx_r, wr_idx_nxt;
  ent_t             h_r, h_nxt;
  ent_t             x_r, x_nxt;
  logic             h_valid_r, h_valid_nxt;
  logic             h_tgt_r, h_tgt_nxt;
  logic             done_r, done_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [GR_W-1:0]  gr_r, gr_nxt;
  logic [CNT_W-1:0] nfree_r, nfree_nxt;
  logic [SZ_W-1:0]  tfree_r, tfree_nxt;
  logic [SZ_W-1:0]  lfree_r, lfree_nxt;
  logic [CNT_W-1:0] merged_r, merged_nxt;

  logic               wr_en;
  logic [IDX_W:0]     wr_addr;
  ent_t               wr_data;
  ent_t               e, e2, seed;
  logic               fit, split, match, merge;
  logic [SZ_W:0]      req_hdr;
  logic [OFF_W-1:0]   pay_off;
  logic [32:0]        pool_clamped;

  assign e       = rd_q_r;
  assign req_hdr = {1'b0, req_r} + (SZ_W+1)'(HEADER_BYTES);
  assign pay_off = e.off + OFF_W'(HEADER_BYTES);
  assign fit     = e.free && ({1'b0, e.size} >= {1'b0, req_r});
  assign split   = (op_r == OP_ALLOC) && !done_r && fit &&
                   ({1'b0, e.size} > req_hdr) && (count_r < CNT_W'(MAX_BLOCKS));
  assign match   = !e.free && (pay_off[REL_W-1:0] == rel_r);

  // clamp the pool to the address range, then drop one header
  always_comb begin
    pool_clamped = {12'd0, pool_bytes};
    if (pool_clamped > POOL_LIMIT) pool_clamped = POOL_LIMIT;
    seed.off  = '0;
    seed.free = 1'b1;
    seed.size = (pool_clamped > 33'(HEADER_BYTES)) ?
                SZ_W'(pool_clamped - 33'(HEADER_BYTES)) : '0;
  end

  assign sts.is_create = (op_r == OP_CREATE);
  assign sts.walk      = present_r && (op_r == OP_ALLOC || op_r == OP_FREE ||
                         op_r == OP_COMPACT || op_r == OP_ANALYZE);
  assign sts.split_req = split;
  assign sts.walk_end  = (rd_idx_r == count_r);

  always_comb begin
    bank_nxt = bank_r;     count_nxt = count_r;   present_nxt = present_r;
    used_nxt = used_r;     op_nxt = op_r;         req_nxt = req_r;
    rel_nxt = rel_r;       rd_idx_nxt = rd_idx_r; wr_idx_nxt = wr_idx_r;
    h_nxt = h_r;           x_nxt = x_r;           h_valid_nxt = h_valid_r;
    h_tgt_nxt = h_tgt_r;   done_nxt = done_r;     st_nxt = st_r;
    gr_nxt = gr_r;         nfree_nxt = nfree_r;   tfree_nxt = tfree_r;
    lfree_nxt = lfree_r;   merged_nxt = merged_r;
    wr_en = 1'b0;
    wr_addr = {~bank_r, wr_idx_r[IDX_W-1:0]};
    wr_data = h_r;
    e2 = e;
    merge = 1'b0;

    if (cmd.start) begin
      op_nxt = in_opcode;
      req_nxt = in_request_bytes;
      rel_nxt = in_release_offset;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      h_valid_nxt = 1'b0;
      h_tgt_nxt = 1'b0;
      done_nxt = 1'b0;
      gr_nxt = '0;
      nfree_nxt = '0;
      tfree_nxt = '0;
      lfree_nxt = '0;
      merged_nxt = '0;
      st_nxt = ST_OK;
      if (in_opcode != OP_CREATE && !present_r &&
          (in_opcode == OP_ALLOC || in_opcode == OP_FREE ||
           in_opcode == OP_COMPACT || in_opcode == OP_ANALYZE)) begin
        st_nxt = ST_NOPOOL;
      end else if (in_opcode == OP_ALLOC) begin
        st_nxt = ST_NOFIT;
      end else if (in_opcode == OP_FREE) begin
        st_nxt = ST_UNKNOWN;
      end
    end

    if (cmd.create) begin
      wr_en = 1'b1;
      wr_addr = {bank_r, {IDX_W{1'b0}}};
      wr_data = seed;
      count_nxt = CNT_W'(1);
      present_nxt = 1'b1;
      used_nxt = SZ_W'(HEADER_BYTES);
    end

    if (cmd.rd) rd_idx_nxt = rd_idx_r + CNT_W'(1);

    if (cmd.proc) begin
      h_tgt_nxt = 1'b0;
      case (op_r)
        OP_ALLOC: begin
          if (!done_r && fit) begin
            done_nxt = 1'b1;
            st_nxt = ST_OK;
            e2.free = 1'b0;
            if (split) begin
              e2.size = req_r;
              x_nxt.off = e.off + OFF_W'(HEADER_BYTES) + OFF_W'(req_r);
              x_nxt.size = SZ_W'({1'b0, e.size} - req_hdr);
              x_nxt.free = 1'b1;
            end
            used_nxt = used_r + e2.size;
            gr_nxt = pay_off[GR_W-1:0];
          end
        end
        OP_FREE: begin
          if (!done_r && match) begin
            done_nxt = 1'b1;
            st_nxt = ST_OK;
            e2.free = 1'b1;
            used_nxt = (used_r >= e.size) ? used_r - e.size : '0;
            merge = h_valid_r && h_r.free;
            h_tgt_nxt = 1'b1;
          end else if (h_tgt_r && e.free) begin
            merge = 1'b1;
          end
        end
        OP_COMPACT: begin
          if (h_valid_r && h_r.free && e.free) begin
            merge = 1'b1;
            merged_nxt = merged_r + CNT_W'(1);
          end
        end
        OP_ANALYZE: begin
          if (e.free) begin
            nfree_nxt = nfree_r + CNT_W'(1);
            tfree_nxt = tfree_r + e.size;
            if (e.size > lfree_r) lfree_nxt = e.size;
          end
        end
        default: ;
      endcase
      if (merge) begin
        h_nxt.size = h_r.size + e.size + SZ_W'(HEADER_BYTES);
      end else begin
        if (h_valid_r) begin
          wr_en = 1'b1;
          wr_idx_nxt = wr_idx_r + CNT_W'(1);
        end
        h_nxt = e2;
        h_valid_nxt = 1'b1;
      end
    end

    if (cmd.split) begin
      wr_en = 1'b1;
      wr_idx_nxt = wr_idx_r + CNT_W'(1);
      h_nxt = x_r;
    end

    if (cmd.flush) begin
      wr_en = h_valid_r;
      count_nxt = wr_idx_r + CNT_W'(h_valid_r);
      bank_nxt = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_q_r <= mem[{bank_r, rd_idx_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= 1'b0;
      count_r   <= '0;
      present_r <= 1'b0;
      used_r    <= '0;
      h_valid_r <= 1'b0;
      h_tgt_r   <= 1'b0;
      done_r    <= 1'b0;
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      op_r      <= OP_CREATE;
    end else begin
      bank_r    <= bank_nxt;
      count_r   <= count_nxt;
      present_r <= present_nxt;
      used_r    <= used_nxt;
      h_valid_r <= h_valid_nxt;
      h_tgt_r   <= h_tgt_nxt;
      done_r    <= done_nxt;
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      op_r      <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rel_r    <= rel_nxt;
    h_r      <= h_nxt;
    x_r      <= x_nxt;
    st_r     <= st_nxt;
    gr_r     <= gr_nxt;
    nfree_r  <= nfree_nxt;
    tfree_r  <= tfree_nxt;
    lfree_r  <= lfree_nxt;
    merged_r <= merged_nxt;
    if (cmd.load) begin
      o_status             <= st_r;
      o_granted_offset     <= gr_r;
      o_used_bytes         <= used_r;
      o_free_block_count   <= 7'(nfree_r);
      o_total_free_bytes   <= tfree_r;
      o_largest_free_bytes <= lfree_r;
      o_merged_count       <= 6'(merged_r);
    end
  end

endmodule

>>> sv/ffpa_chk.sv
// port-level checker for the allocator, bound to the top level
// depends on ffpa_pkg
module ffpa_chk
  import ffpa_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [47:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is at work");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[21:2] == '0)
    else $error("offset granted on a failed item");

  a_nopool_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_NOPOOL |->
      out_tdata[97:92] == '0 && out_tdata[49:43] == '0 && out_tdata[42:22] == '0)
    else $error("no-pool result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind first_fit_pool_allocator ffpa_chk u_ffpa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
